// File: rtl/dop_pkg.sv
// Shared constants and types for the degenerate octree point indexer.
package dop_pkg;

	localparam int MAX_LEVELS = 21;
	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = (COORD_BITS > MAX_LEVELS) ? COORD_BITS : MAX_LEVELS;
	localparam int BND_W      = FRAC_BITS + 1;
	localparam int LVL_W      = 5;
	localparam int IDX_W      = 64;

	typedef enum logic [2:0] {
		KIND_RADIAL = 3'b001,
		KIND_UPPER  = 3'b010,
		KIND_FULL   = 3'b100
	} kind_t;

	// One point in flight along the cell chain.
	typedef struct packed {
		logic                  vld;
		logic [LVL_W-1:0]      rem;
		kind_t                 kind;
		logic [FRAC_BITS-1:0]  pr;
		logic [FRAC_BITS-1:0]  pa;
		logic [FRAC_BITS-1:0]  po;
		logic [BND_W-1:0]      rlo;
		logic [BND_W-1:0]      rhi;
		logic [BND_W-1:0]      alo;
		logic [BND_W-1:0]      ahi;
		logic [BND_W-1:0]      olo;
		logic [BND_W-1:0]      ohi;
		logic [IDX_W-1:0]      idx;
	} tok_t;

endpackage

// File: rtl/dop_cell.sv
// One level of the octree descent: split bounds, append a child code, register.
module dop_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  dop_pkg::tok_t tin,
	output dop_pkg::tok_t tout
);
	import dop_pkg::*;

	tok_t             nxt;
	tok_t             tok_q;
	logic             vld_q;
	logic [BND_W:0]   rsum;
	logic [BND_W:0]   asum;
	logic [BND_W:0]   osum;
	logic [BND_W-1:0] rm;
	logic [BND_W-1:0] am;
	logic [BND_W-1:0] om;
	logic             rup;
	logic             aup;
	logic             oup;
	logic             split_a;
	logic             split_o;
	logic [2:0]       code;

	assign rsum = {1'b0, tin.rlo} + {1'b0, tin.rhi};
	assign asum = {1'b0, tin.alo} + {1'b0, tin.ahi};
	assign osum = {1'b0, tin.olo} + {1'b0, tin.ohi};
	assign rm   = rsum[BND_W:1];
	assign am   = asum[BND_W:1];
	assign om   = osum[BND_W:1];
	// radius strict, angles go high on a tie
	assign rup  = {1'b0, tin.pr} > rm;
	assign aup  = {1'b0, tin.pa} >= am;
	assign oup  = {1'b0, tin.po} >= om;

	always_comb begin
		nxt     = tin;
		split_a = 1'b0;
		split_o = 1'b0;
		unique case (tin.kind)
			KIND_FULL: begin
				split_a = 1'b1;
				split_o = 1'b1;
			end
			KIND_UPPER: begin
				split_a = 1'b1;
				split_o = ~aup;
				if (!aup) begin
					nxt.kind = KIND_FULL;
				end
			end
			KIND_RADIAL: begin
				split_a = rup;
				split_o = rup & ~aup;
				if (rup) begin
					nxt.kind = aup ? KIND_UPPER : KIND_FULL;
				end
			end
			default: begin
				split_a = 1'b0;
				split_o = 1'b0;
			end
		endcase

		code = {~rup, split_a & aup, split_o & oup};

		if (rup) begin
			nxt.rlo = rm;
		end else begin
			nxt.rhi = rm;
		end
		if (split_a) begin
			if (aup) begin
				nxt.alo = am;
			end else begin
				nxt.ahi = am;
			end
		end
		if (split_o) begin
			if (oup) begin
				nxt.olo = om;
			end else begin
				nxt.ohi = om;
			end
		end
		nxt.idx = {tin.idx[IDX_W-4:0], code};
		nxt.rem = tin.rem - LVL_W'(1);

		// level not requested: pass through untouched
		if (tin.rem == '0) begin
			nxt = tin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tin.vld;
		end
	end

	// payload needs no reset, only the valid flag does
	always_ff @(posedge clk) begin
		tok_q <= nxt;
	end

	always_comb begin
		tout     = tok_q;
		tout.vld = vld_q;
	end

endmodule

// File: rtl/degenerate_octree_point_index.sv
// Top level: degenerate octree point indexer built as a chain of level cells.
//
// A transaction is taken at a rising edge with start high and busy low; busy is
// high during reset and up to the first rising edge after its release, so one
// point can be started every cycle from then on. Each point walks a row of
// MAX_LEVELS (21) identical registered cells, one cell per octree level, and its
// index appears on cell_index with done high once it leaves the last cell, in
// start order. done and cell_index last one cycle only: the receiver cannot
// stall, so it must capture them then. Levels above MAX_LEVELS are clipped to
// MAX_LEVELS; a level count of zero gives an index of 1.
module degenerate_octree_point_index (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [31:0]                    rad_frac,
	input  logic [31:0]                    lat_frac,
	input  logic [31:0]                    lng_frac,
	input  logic [4:0]                     levels,
	output logic                           done,
	output logic [63:0]                    cell_index
);
	import dop_pkg::*;

	tok_t chain [MAX_LEVELS+1];
	logic busy_q;
	logic [LVL_W-1:0] lvl_sat;

	// busy only while coming out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end
	assign busy = busy_q;

	assign lvl_sat = (levels > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : levels;

	// Head of the chain: root cell is radial-only, bounds span the full range.
	// Coordinates keep their low COORD_BITS and are scaled up to FRAC_BITS.
	always_comb begin
		chain[0].vld  = start & ~busy_q;
		chain[0].rem  = lvl_sat;
		chain[0].kind = KIND_RADIAL;
		chain[0].pr   = FRAC_BITS'(rad_frac[COORD_BITS-1:0]) << (FRAC_BITS - COORD_BITS);
		chain[0].pa   = FRAC_BITS'(lat_frac[COORD_BITS-1:0]) << (FRAC_BITS - COORD_BITS);
		chain[0].po   = FRAC_BITS'(lng_frac[COORD_BITS-1:0]) << (FRAC_BITS - COORD_BITS);
		chain[0].rlo  = '0;
		chain[0].rhi  = BND_W'(1) << FRAC_BITS;
		chain[0].alo  = '0;
		chain[0].ahi  = BND_W'(1) << FRAC_BITS;
		chain[0].olo  = '0;
		chain[0].ohi  = BND_W'(1) << FRAC_BITS;
		chain[0].idx  = IDX_W'(1);
	end

	// one cell per level; a cell whose level is not requested passes the point on
	for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
		dop_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tin    (chain[g]),
			.tout   (chain[g+1])
		);
	end

	assign done       = chain[MAX_LEVELS].vld;
	assign cell_index = chain[MAX_LEVELS].idx;

endmodule

// File: rtl/dop_chk.sv
// Port-level checker for the octree point indexer, bound to the top level.
module dop_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [4:0]  levels,
	input logic        done,
	input logic [63:0] cell_index
);
	import dop_pkg::*;

	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##MAX_LEVELS done)
		else $error("started transaction did not complete on time");

	a_lat_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, MAX_LEVELS))
		else $error("result without a matching start");

	a_lead_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cell_index != '0))
		else $error("cell index lost its leading one");

	a_zero_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && levels == '0) |-> ##MAX_LEVELS (cell_index == 64'd1))
		else $error("zero-level transaction gave an index other than root");

endmodule

bind degenerate_octree_point_index dop_chk u_dop_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.levels     (levels),
	.done       (done),
	.cell_index (cell_index)
);

// File: tb/octree_index_checker.sv
// Checker for the degenerate octree point indexer: predicts and compares cell indexes.
`timescale 1ns / 100ps

module octree_index_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [31:0]               rad_frac,
	input  logic [31:0]               lat_frac,
	input  logic [31:0]               lng_frac,
	input  logic [dop_pkg::LVL_W-1:0] levels,
	input  logic                      done,
	input  logic [dop_pkg::IDX_W-1:0] cell_index,
	output int                        mismatches,
	output int                        outstanding
);
	import dop_pkg::*;

	localparam int REPORT_MAX = 10;

	typedef struct {
		logic [31:0]      rad;
		logic [31:0]      lat;
		logic [31:0]      lng;
		logic [LVL_W-1:0] lvl;
		logic [IDX_W-1:0] index;
	} point_rec_t;

	point_rec_t index_q[$];

	// Walk the cell kinds level by level, one 3-bit child code per level.
	function automatic logic [IDX_W-1:0] octree_cell_index(
		input logic [31:0] rad, lat, lng, input logic [LVL_W-1:0] lvl);
		logic [FRAC_BITS-1:0] pr, pa, po;
		logic [BND_W-1:0]     rlo, rhi, alo, ahi, olo, ohi, rm, am, om;
		logic [2:0]           code;
		logic                 rup, aup, oup;
		kind_t                kind;
		int                   depth;
		logic [IDX_W-1:0]     idx;
		pr = FRAC_BITS'(rad[COORD_BITS-1:0]) << (FRAC_BITS - COORD_BITS);
		pa = FRAC_BITS'(lat[COORD_BITS-1:0]) << (FRAC_BITS - COORD_BITS);
		po = FRAC_BITS'(lng[COORD_BITS-1:0]) << (FRAC_BITS - COORD_BITS);
		rlo = '0;
		alo = '0;
		olo = '0;
		rhi = BND_W'(1) << FRAC_BITS;
		ahi = rhi;
		ohi = rhi;
		depth = (lvl > MAX_LEVELS) ? MAX_LEVELS : int'(lvl);
		kind = KIND_RADIAL;
		idx = IDX_W'(1);
		for (int i = 0; i < depth; i++) begin
			rm = (rlo + rhi) >> 1;
			am = (alo + ahi) >> 1;
			om = (olo + ohi) >> 1;
			rup = BND_W'(pr) > rm;   // radius ties go low
			aup = BND_W'(pa) >= am;  // angle ties go high
			oup = BND_W'(po) >= om;
			code = '0;
			if (rup) begin
				rlo = rm;
			end else begin
				rhi = rm;
				code[2] = 1'b1;
			end
			case (kind)
				KIND_FULL: begin
					if (aup) begin
						alo = am;
						code[1] = 1'b1;
					end else begin
						ahi = am;
					end
					if (oup) begin
						olo = om;
						code[0] = 1'b1;
					end else begin
						ohi = om;
					end
				end
				KIND_UPPER: begin
					if (aup) begin
						alo = am;
						code[1] = 1'b1;
					end else begin
						ahi = am;
						kind = KIND_FULL;
						if (oup) begin
							olo = om;
							code[0] = 1'b1;
						end else begin
							ohi = om;
						end
					end
				end
				default: begin
					// radial cell: only its upper radial child splits in angle
					if (rup) begin
						if (aup) begin
							alo = am;
							code[1] = 1'b1;
							kind = KIND_UPPER;
						end else begin
							ahi = am;
							kind = KIND_FULL;
							if (oup) begin
								olo = om;
								code[0] = 1'b1;
							end else begin
								ohi = om;
							end
						end
					end
				end
			endcase
			idx = {idx[IDX_W-4:0], code};
		end
		return idx;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		point_rec_t rec;
		if (!arst_n) begin
			index_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if ($isunknown(done)) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: done is unknown", $realtime);
			end else if (done) begin
				if (index_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: cell_index %h with no point outstanding",
							$realtime, cell_index);
				end else begin
					rec = index_q.pop_front();
					if (cell_index !== rec.index) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("%0t: r=%h a=%h o=%h lv=%0d expected %h got %h",
								$realtime, rec.rad, rec.lat, rec.lng, rec.lvl,
								rec.index, cell_index);
					end
				end
			end
			if (start && !busy) begin
				rec.rad = rad_frac;
				rec.lat = lat_frac;
				rec.lng = lng_frac;
				rec.lvl = levels;
				rec.index = octree_cell_index(rad_frac, lat_frac, lng_frac, levels);
				index_q.push_back(rec);
			end
			outstanding = index_q.size();
		end
	end

endmodule

// File: tb/degenerate_octree_point_index_tb.sv
// Testbench top for the degenerate octree point indexer: stimulus and verdict.
`timescale 1ns / 100ps

module degenerate_octree_point_index_tb;
	import dop_pkg::*;

	// Random points per idle phase; three phases give roughly 650 in all.
	localparam int PHASE_POINTS   = 217;
	// Cycles with no transaction on either side before the run is called hung.
	// A correct run never goes quiet for more than the pipeline depth plus a
	// sender gap, so this is many times the worst case.
	localparam int WATCHDOG_LIMIT = 5000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [31:0]      rad_frac;
	logic [31:0]      lat_frac;
	logic [31:0]      lng_frac;
	logic [LVL_W-1:0] levels;
	logic             done;
	logic [IDX_W-1:0] cell_index;

	int mismatches;
	int outstanding;
	int idle_pct;
	int quiet_cycles;

	degenerate_octree_point_index dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.rad_frac  (rad_frac),
		.lat_frac  (lat_frac),
		.lng_frac  (lng_frac),
		.levels    (levels),
		.done      (done),
		.cell_index(cell_index)
	);

	octree_index_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.rad_frac   (rad_frac),
		.lat_frac   (lat_frac),
		.lng_frac   (lng_frac),
		.levels     (levels),
		.done       (done),
		.cell_index (cell_index),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hang detection: any accepted transaction, in or out, resets the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one point and hold it until it is taken. Called right after a rising
	// edge; returns right after the edge that accepted it. Random idle cycles
	// go first, with junk on the fields so only start qualifies the transaction.
	// busy is looked at on the falling edge, where it is settled.
	task automatic send_point(input logic [31:0] r, a, o, input logic [LVL_W-1:0] l);
		logic took;
		while ($urandom_range(99) < idle_pct) begin
			start    <= 1'b0;
			rad_frac <= $urandom;
			lat_frac <= $urandom;
			lng_frac <= $urandom;
			levels   <= LVL_W'($urandom);
			@(posedge clk);
		end
		start    <= 1'b1;
		rad_frac <= r;
		lat_frac <= a;
		lng_frac <= o;
		levels   <= l;
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
	endtask

	// Stop sending and wait until every predicted index has come back.
	task automatic drain_indexes();
		start <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		@(posedge clk);
	endtask

	// Coordinates skewed toward the places where the compares are interesting:
	// exact midpoints at some level, one off a midpoint, and the span ends.
	function automatic logic [31:0] pick_coord();
		logic [31:0] v;
		int          k;
		v = $urandom;
		k = $urandom_range(10, 31);
		case ($urandom_range(7)) inside
			0: v = 32'h0;
			1: v = 32'hFFFF_FFFF;
			2, 3: v = (v & ~((32'h1 << k) - 32'h1)) | (32'h1 << k);
			4: v = ((v & ~((32'h1 << k) - 32'h1)) | (32'h1 << k))
				+ ($urandom_range(1) ? 32'h1 : 32'hFFFF_FFFF);
			default: ;
		endcase
		return v;
	endfunction

	// Mostly full depth, with the clipped counts and short walks mixed in.
	function automatic logic [LVL_W-1:0] pick_levels();
		if ($urandom_range(3) == 0)
			return LVL_W'($urandom_range(0, 31));
		return LVL_W'($urandom_range(MAX_LEVELS - 2, MAX_LEVELS));
	endfunction

	initial begin
		arst_n   <= 1'b0;
		start    <= 1'b0;
		rad_frac <= '0;
		lat_frac <= '0;
		lng_frac <= '0;
		levels   <= '0;
		idle_pct = 25;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed points: span ends, level clipping, ties at the root and at
		// the deepest level, and each path through the cell kinds.
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 5'd0);
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 5'd21);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd21);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 5'd21);
		send_point(32'h8000_0001, 32'h8000_0000, 32'h8000_0000, 5'd21);
		send_point(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 5'd21);
		send_point(32'hC000_0000, 32'hC000_0000, 32'h4000_0000, 5'd21);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 5'd21);
		send_point(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 5'd21);
		send_point(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd21);
		send_point(32'h0000_0800, 32'h0000_0800, 32'h0000_0800, 5'd21);
		send_point(32'hFFFF_F800, 32'hFFFF_F800, 32'hFFFF_F800, 5'd21);
		send_point(32'hFFFF_F801, 32'hFFFF_F7FF, 32'hFFFF_F800, 5'd22);
		send_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 5'd20);
		send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 5'd1);
		send_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 5'd22);
		send_point(32'h8000_0001, 32'h4000_0000, 32'hC000_0000, 5'd5);

		// Random points in three sender idle regimes; each phase ends by
		// pausing until the pipeline is empty.
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 25 : (phase == 1) ? 52 : 0;
			for (int n = 0; n < PHASE_POINTS; n++)
				send_point(pick_coord(), pick_coord(), pick_coord(), pick_levels());
			drain_indexes();
		end

		// Let any stray strobe out of the pipeline show up before the verdict.
		repeat (MAX_LEVELS + 10) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
